FILE: src/rpaw_pkg.sv
// Package for the radio PHY ack-wait controller.
// Holds event codes, the one-hot PHY state type, frame constants and the RSSI conversion.
// No dependencies.
package rpaw_pkg;

    // Event codes carried in the kind field
    typedef enum logic [2:0] {
        KIND_ENABLE   = 3'd0,
        KIND_DISABLE  = 3'd1,
        KIND_SLEEP    = 3'd2,
        KIND_RECEIVE  = 3'd3,
        KIND_TX_REQ   = 3'd4,
        KIND_TICK     = 3'd5,
        KIND_IRQ      = 3'd6
    } kind_t;

    // PHY state, one-hot
    typedef enum logic [3:0] {
        PHY_DISABLED = 4'b0001,
        PHY_SLEEP    = 4'b0010,
        PHY_RECEIVE  = 4'b0100,
        PHY_TRANSMIT = 4'b1000
    } phy_state_t;

    // Reported state codes
    localparam logic [1:0] PHY_CODE_DISABLED = 2'd0;
    localparam logic [1:0] PHY_CODE_SLEEP    = 2'd1;
    localparam logic [1:0] PHY_CODE_RECEIVE  = 2'd2;
    localparam logic [1:0] PHY_CODE_TRANSMIT = 2'd3;

    // Frame control fields
    localparam logic [7:0] FC_LONG_HDR_MASK = 8'hC0;
    localparam int         FC_ACK_REQ_BIT   = 5;
    localparam int         FC_PENDING_BIT   = 4;
    localparam logic [2:0] FC_TYPE_ACK      = 3'd2;

    // Header lengths
    localparam logic [3:0] HDR_LEN_LONG  = 4'd15;
    localparam logic [3:0] HDR_LEN_SHORT = 4'd7;

    // rss/5 as (rss*205)>>10, exact over 8-bit inputs
    localparam logic [7:0] RSS_DIV5_MUL   = 8'd205;
    localparam int         RSS_DIV5_SHIFT = 10;
    localparam logic [7:0] RSSI_OFFSET    = 8'd90;

    function automatic logic [1:0] phy_code(input phy_state_t st);
        logic [1:0] code;
        unique case (st)
            PHY_DISABLED: code = PHY_CODE_DISABLED;
            PHY_SLEEP:    code = PHY_CODE_SLEEP;
            PHY_RECEIVE:  code = PHY_CODE_RECEIVE;
            PHY_TRANSMIT: code = PHY_CODE_TRANSMIT;
            default:      code = PHY_CODE_DISABLED;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] rss_to_dbm(input logic [7:0] rss);
        logic [15:0] prod;
        logic [5:0]  quot;
        prod = rss * RSS_DIV5_MUL;
        quot = prod[15:RSS_DIV5_SHIFT];
        return {2'b00, quot} - RSSI_OFFSET;
    endfunction

endpackage

FILE: src/radio_phy_ack_wait_fsm.sv
// Radio PHY state controller for an 802.15.4 transceiver, top level.
// Depends on rpaw_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready): one event per transaction, coded in
//   s_kind (enable, disable, sleep, receive, transmit request, process tick,
//   interrupt) with the channel, transmit frame fields and interrupt status.
//   Result channel (m_valid/m_ready): exactly one result per event: command
//   status, PHY state after the event, transmit start and header length,
//   transmit done / frame pending / error, receive delivery and RSSI in dBm.
//   Path: an accepted event goes into the input register, then through one pass
//   of state logic into the result register, which drives the result channel.
//   Throughput: one event per cycle while the result channel is not stalled,
//   with the state update between the input register and the result register.
//   Reset (aresetn low, synchronous): PHY disabled, all flags and latched
//   frame fields cleared, both pipeline registers empty.
//   Receiver stall: the result register holds; the input register still takes
//   one more event, then s_ready drops until the result is taken.
module radio_phy_ack_wait_fsm
    import rpaw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // event channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_kind,
    input  logic [4:0]        s_channel,
    input  logic [7:0]        s_tx_frame_ctrl,
    input  logic [7:0]        s_tx_seq,
    input  logic              s_tx_irq,
    input  logic              s_tx_fail_status,
    input  logic              s_rx_irq,
    input  logic [7:0]        s_rx_frame_ctrl,
    input  logic [7:0]        s_rx_seq,
    input  logic [7:0]        s_rx_rss,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_status,
    output logic [1:0]        m_phy_state_out,
    output logic              m_start_tx,
    output logic [3:0]        m_header_len,
    output logic              m_tx_done,
    output logic              m_frame_pending,
    output logic              m_tx_error,
    output logic              m_rx_deliver,
    output logic signed [7:0] m_rssi_dbm
);

    // Input register
    logic       in_valid_reg, in_valid_next;
    kind_t      in_kind_reg;
    logic [4:0] in_channel_reg;
    logic [7:0] in_tx_ctrl_reg;
    logic [7:0] in_tx_seq_reg;
    logic       in_tx_irq_reg;
    logic       in_tx_fail_reg;
    logic       in_rx_irq_reg;
    logic [7:0] in_rx_ctrl_reg;
    logic [7:0] in_rx_seq_reg;
    logic [7:0] in_rx_rss_reg;

    // Controller state
    phy_state_t phy_state_reg, phy_state_next;
    logic       ack_wait_reg, ack_wait_next;
    logic       transmitting_reg, transmitting_next;
    logic [7:0] pending_ctrl_reg, pending_ctrl_next;
    logic [7:0] pending_seq_reg, pending_seq_next;
    logic [4:0] pending_chan_reg, pending_chan_next;
    logic [4:0] listen_chan_reg, listen_chan_next;
    logic [7:0] last_rss_reg, last_rss_next;
    logic       fail_flag_reg, fail_flag_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    logic       out_status_reg, out_status_next;
    logic [1:0] out_phy_reg, out_phy_next;
    logic       out_start_reg, out_start_next;
    logic [3:0] out_hlen_reg, out_hlen_next;
    logic       out_done_reg, out_done_next;
    logic       out_fpend_reg, out_fpend_next;
    logic       out_deliver_reg, out_deliver_next;
    logic [7:0] out_dbm_reg, out_dbm_next;

    logic in_accept;
    logic out_free;
    logic process;
    logic can_start;

    // Handshake and pipeline advance
    assign out_free  = !out_valid_reg || m_ready;
    assign process   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign in_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (process) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign can_start = (phy_state_reg == PHY_TRANSMIT) && !ack_wait_reg && !transmitting_reg;

    // Event processing: next state and result for the registered event
    always_comb begin
        phy_state_next    = phy_state_reg;
        ack_wait_next     = ack_wait_reg;
        transmitting_next = transmitting_reg;
        pending_ctrl_next = pending_ctrl_reg;
        pending_seq_next  = pending_seq_reg;
        pending_chan_next = pending_chan_reg;
        listen_chan_next  = listen_chan_reg;
        last_rss_next     = last_rss_reg;
        fail_flag_next    = fail_flag_reg;
        out_status_next   = 1'b0;
        out_start_next    = 1'b0;
        out_hlen_next     = 4'd0;
        out_done_next     = 1'b0;
        out_fpend_next    = 1'b0;
        out_deliver_next  = 1'b0;

        unique case (in_kind_reg)
            KIND_ENABLE: begin
                if (phy_state_reg == PHY_SLEEP || phy_state_reg == PHY_DISABLED) begin
                    phy_state_next = PHY_SLEEP;
                end else begin
                    out_status_next = 1'b1;
                end
            end
            KIND_DISABLE: begin
                if (phy_state_reg == PHY_SLEEP || phy_state_reg == PHY_DISABLED) begin
                    phy_state_next = PHY_DISABLED;
                end else begin
                    out_status_next = 1'b1;
                end
            end
            KIND_SLEEP: begin
                if (!(phy_state_reg == PHY_SLEEP || phy_state_reg == PHY_RECEIVE)) begin
                    out_status_next = 1'b1;
                end
                phy_state_next = PHY_SLEEP;
            end
            KIND_RECEIVE: begin
                if (phy_state_reg != PHY_DISABLED) begin
                    phy_state_next   = PHY_RECEIVE;
                    listen_chan_next = in_channel_reg;
                end else begin
                    out_status_next = 1'b1;
                end
            end
            KIND_TX_REQ: begin
                if (can_start || phy_state_reg == PHY_RECEIVE) begin
                    phy_state_next    = PHY_TRANSMIT;
                    pending_ctrl_next = in_tx_ctrl_reg;
                    pending_seq_next  = in_tx_seq_reg;
                    pending_chan_next = in_channel_reg;
                end else begin
                    out_status_next = 1'b1;
                end
            end
            KIND_TICK: begin
                if (can_start) begin
                    out_start_next    = 1'b1;
                    out_hlen_next     = ((pending_ctrl_reg & FC_LONG_HDR_MASK) != 8'd0)
                                        ? HDR_LEN_LONG : HDR_LEN_SHORT;
                    transmitting_next = 1'b1;
                    ack_wait_next     = pending_ctrl_reg[FC_ACK_REQ_BIT];
                end
            end
            KIND_IRQ: begin
                // transmit-complete first
                if (in_tx_irq_reg && transmitting_reg) begin
                    transmitting_next = 1'b0;
                    fail_flag_next    = in_tx_fail_reg;
                    if (!ack_wait_reg) begin
                        phy_state_next = PHY_RECEIVE;
                        out_done_next  = 1'b1;
                    end
                end
                // then received frame, seen against the updated flags
                if (in_rx_irq_reg && !transmitting_next &&
                    (phy_state_next != PHY_TRANSMIT || ack_wait_next)) begin
                    last_rss_next = in_rx_rss_reg;
                    if (ack_wait_next && pending_chan_reg == listen_chan_reg &&
                        in_rx_ctrl_reg[2:0] == FC_TYPE_ACK) begin
                        if (pending_seq_reg == in_rx_seq_reg) begin
                            phy_state_next = PHY_RECEIVE;
                            ack_wait_next  = 1'b0;
                            out_done_next  = 1'b1;
                            out_fpend_next = in_rx_ctrl_reg[FC_PENDING_BIT];
                        end
                    end else if (phy_state_next == PHY_RECEIVE) begin
                        out_deliver_next = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        out_phy_next = phy_code(phy_state_next);
        out_dbm_next = rss_to_dbm(last_rss_next);
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phy_state_reg    <= PHY_DISABLED;
            ack_wait_reg     <= 1'b0;
            transmitting_reg <= 1'b0;
            pending_ctrl_reg <= 8'd0;
            pending_seq_reg  <= 8'd0;
            pending_chan_reg <= 5'd0;
            listen_chan_reg  <= 5'd0;
            last_rss_reg     <= 8'd0;
            fail_flag_reg    <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process) begin
                phy_state_reg    <= phy_state_next;
                ack_wait_reg     <= ack_wait_next;
                transmitting_reg <= transmitting_next;
                pending_ctrl_reg <= pending_ctrl_next;
                pending_seq_reg  <= pending_seq_next;
                pending_chan_reg <= pending_chan_next;
                listen_chan_reg  <= listen_chan_next;
                last_rss_reg     <= last_rss_next;
                fail_flag_reg    <= fail_flag_next;
            end
        end
    end

    // Input payload register
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_kind_reg    <= kind_t'(s_kind);
            in_channel_reg <= s_channel;
            in_tx_ctrl_reg <= s_tx_frame_ctrl;
            in_tx_seq_reg  <= s_tx_seq;
            in_tx_irq_reg  <= s_tx_irq;
            in_tx_fail_reg <= s_tx_fail_status;
            in_rx_irq_reg  <= s_rx_irq;
            in_rx_ctrl_reg <= s_rx_frame_ctrl;
            in_rx_seq_reg  <= s_rx_seq;
            in_rx_rss_reg  <= s_rx_rss;
        end
    end

    // Result payload register
    always_ff @(posedge aclk) begin
        if (process) begin
            out_status_reg  <= out_status_next;
            out_phy_reg     <= out_phy_next;
            out_start_reg   <= out_start_next;
            out_hlen_reg    <= out_hlen_next;
            out_done_reg    <= out_done_next;
            out_fpend_reg   <= out_fpend_next;
            out_deliver_reg <= out_deliver_next;
            out_dbm_reg     <= out_dbm_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_phy_state_out = out_phy_reg;
    assign m_start_tx      = out_start_reg;
    assign m_header_len    = out_hlen_reg;
    assign m_tx_done       = out_done_reg;
    assign m_frame_pending = out_fpend_reg;
    assign m_tx_error      = fail_flag_reg;
    assign m_rx_deliver    = out_deliver_reg;
    assign m_rssi_dbm      = signed'(out_dbm_reg);

    // Checks
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phy_state_reg))
        else $error("PHY state register not one-hot");

    a_start_hlen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_start_tx) |->
            (m_header_len == HDR_LEN_LONG || m_header_len == HDR_LEN_SHORT))
        else $error("started frame with bad header length");

    a_nostart_hlen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_start_tx) |-> (m_header_len == 4'd0))
        else $error("header length set without a start");

    a_start_in_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_start_tx) |-> (m_phy_state_out == PHY_CODE_TRANSMIT && transmitting_reg))
        else $error("start reported outside transmit");

    a_pending_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_pending) |->
            (m_tx_done && m_phy_state_out == PHY_CODE_RECEIVE && !ack_wait_reg))
        else $error("frame pending without a matched ack");

endmodule

FILE: dv/radio_phy_ack_wait_fsm_tb.sv
// Self-checking testbench for radio_phy_ack_wait_fsm: directed and random event streams with
// random idling on both channels, results checked against an in-bench PHY state predictor.
// Depends on rpaw_pkg and the radio_phy_ack_wait_fsm RTL.
module radio_phy_ack_wait_fsm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpaw_pkg::*;

    localparam logic [2:0] KIND_UNUSED  = 3'd7;
    localparam int         RANDOM_ITEMS = 1800;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_AT      = 400;
    localparam int         HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] channel;
        logic [7:0] tx_frame_ctrl;
        logic [7:0] tx_seq;
        logic       tx_irq;
        logic       tx_fail_status;
        logic       rx_irq;
        logic [7:0] rx_frame_ctrl;
        logic [7:0] rx_seq;
        logic [7:0] rx_rss;
    } phy_event_t;

    typedef struct packed {
        logic       status;
        logic [1:0] phy_state;
        logic       start_tx;
        logic [3:0] header_len;
        logic       tx_done;
        logic       frame_pending;
        logic       tx_error;
        logic       rx_deliver;
        logic [7:0] rssi_dbm;
    } phy_result_t;

    // DUT signals
    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [2:0]        s_kind = '0;
    logic [4:0]        s_channel = '0;
    logic [7:0]        s_tx_frame_ctrl = '0;
    logic [7:0]        s_tx_seq = '0;
    logic              s_tx_irq = 1'b0;
    logic              s_tx_fail_status = 1'b0;
    logic              s_rx_irq = 1'b0;
    logic [7:0]        s_rx_frame_ctrl = '0;
    logic [7:0]        s_rx_seq = '0;
    logic [7:0]        s_rx_rss = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_status;
    logic [1:0]        m_phy_state_out;
    logic              m_start_tx;
    logic [3:0]        m_header_len;
    logic              m_tx_done;
    logic              m_frame_pending;
    logic              m_tx_error;
    logic              m_rx_deliver;
    logic signed [7:0] m_rssi_dbm;

    // Predicted PHY state
    logic [1:0] phy_st;
    logic       ack_wait_q;
    logic       tx_busy_q;
    logic [7:0] pend_ctrl;
    logic [7:0] pend_seq;
    logic [4:0] pend_ch;
    logic [4:0] listen_ch;
    logic [7:0] rss_q;
    logic       fail_q;

    phy_event_t  ev_pending[$];
    phy_result_t phy_results_due[$];

    // Handshake bookkeeping
    logic ev_taken = 1'b0;
    logic res_taken = 1'b0;
    int   src_gap = 0;
    int   snk_gap = 0;
    logic src_burst = 1'b0;
    logic snk_burst = 1'b0;
    int   long_hold = 0;
    logic long_hold_done = 1'b0;

    int n_queued = 0;
    int events_sent = 0;
    int results_checked = 0;
    int fault_count = 0;
    int cycle_cnt = 0;
    int n_busy = 0;
    int n_starts = 0;
    int n_done = 0;
    int n_pending = 0;
    int n_deliver = 0;

    radio_phy_ack_wait_fsm i_dut (.*);

    // Clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // Next PHY result for one event; updates the predicted state
    function automatic phy_result_t advance_phy(input phy_event_t ev);
        phy_result_t r;
        logic        may_start;
        r = '0;
        may_start = (phy_st == PHY_CODE_TRANSMIT) && !ack_wait_q && !tx_busy_q;
        case (ev.kind)
            KIND_ENABLE: begin
                if (phy_st == PHY_CODE_SLEEP || phy_st == PHY_CODE_DISABLED) phy_st = PHY_CODE_SLEEP;
                else r.status = 1'b1;
            end
            KIND_DISABLE: begin
                if (phy_st == PHY_CODE_SLEEP || phy_st == PHY_CODE_DISABLED) begin
                    phy_st = PHY_CODE_DISABLED;
                end else begin
                    r.status = 1'b1;
                end
            end
            KIND_SLEEP: begin
                if (!(phy_st == PHY_CODE_SLEEP || phy_st == PHY_CODE_RECEIVE)) r.status = 1'b1;
                phy_st = PHY_CODE_SLEEP;
            end
            KIND_RECEIVE: begin
                if (phy_st != PHY_CODE_DISABLED) begin
                    phy_st = PHY_CODE_RECEIVE;
                    listen_ch = ev.channel;
                end else begin
                    r.status = 1'b1;
                end
            end
            KIND_TX_REQ: begin
                if (may_start || phy_st == PHY_CODE_RECEIVE) begin
                    phy_st = PHY_CODE_TRANSMIT;
                    pend_ctrl = ev.tx_frame_ctrl;
                    pend_seq = ev.tx_seq;
                    pend_ch = ev.channel;
                end else begin
                    r.status = 1'b1;
                end
            end
            KIND_TICK: begin
                if (may_start) begin
                    r.start_tx = 1'b1;
                    r.header_len = ((pend_ctrl & FC_LONG_HDR_MASK) != 0) ? HDR_LEN_LONG
                                                                         : HDR_LEN_SHORT;
                    tx_busy_q = 1'b1;
                    ack_wait_q = pend_ctrl[FC_ACK_REQ_BIT];
                end
            end
            KIND_IRQ: begin
                // transmit complete is handled before the received frame
                if (ev.tx_irq && tx_busy_q) begin
                    tx_busy_q = 1'b0;
                    fail_q = ev.tx_fail_status;
                    if (!ack_wait_q) begin
                        phy_st = PHY_CODE_RECEIVE;
                        r.tx_done = 1'b1;
                    end
                end
                if (ev.rx_irq && !tx_busy_q && (phy_st != PHY_CODE_TRANSMIT || ack_wait_q)) begin
                    rss_q = ev.rx_rss;
                    if (ack_wait_q && pend_ch == listen_ch &&
                            ev.rx_frame_ctrl[2:0] == FC_TYPE_ACK) begin
                        // ack with a wrong sequence number is dropped
                        if (pend_seq == ev.rx_seq) begin
                            phy_st = PHY_CODE_RECEIVE;
                            ack_wait_q = 1'b0;
                            r.tx_done = 1'b1;
                            r.frame_pending = ev.rx_frame_ctrl[FC_PENDING_BIT];
                        end
                    end else if (phy_st == PHY_CODE_RECEIVE) begin
                        r.rx_deliver = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.phy_state = phy_st;
        r.tx_error = fail_q;
        r.rssi_dbm = rss_q / 8'd5 - 8'd90;
        return r;
    endfunction

    function automatic phy_event_t rand_event();
        phy_event_t e;
        e = phy_event_t'({$urandom(), $urandom()});
        return e;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            fault_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // Acceptance, prediction and result checking at the rising edge
    always @(posedge aclk) begin
        phy_result_t exp_r;
        ev_taken = 1'b0;
        res_taken = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                res_taken = 1'b1;
                results_checked++;
                if (phy_results_due.size() == 0) begin
                    fault_count++;
                    $display("%0t ns: result with no transaction outstanding, state %0d",
                             $time, m_phy_state_out);
                end else begin
                    exp_r = phy_results_due.pop_front();
                    check_field("status", exp_r.status, m_status);
                    check_field("phy_state_out", exp_r.phy_state, m_phy_state_out);
                    check_field("start_tx", exp_r.start_tx, m_start_tx);
                    check_field("header_len", exp_r.header_len, m_header_len);
                    check_field("tx_done", exp_r.tx_done, m_tx_done);
                    check_field("frame_pending", exp_r.frame_pending, m_frame_pending);
                    check_field("tx_error", exp_r.tx_error, m_tx_error);
                    check_field("rx_deliver", exp_r.rx_deliver, m_rx_deliver);
                    check_field("rssi_dbm", int'($signed(exp_r.rssi_dbm)), int'(m_rssi_dbm));
                end
                n_busy += m_status;
                n_starts += m_start_tx;
                n_done += m_tx_done;
                n_pending += m_frame_pending;
                n_deliver += m_rx_deliver;
            end
            if (s_valid && s_ready) begin
                ev_taken = 1'b1;
                events_sent++;
                phy_results_due.push_back(advance_phy({s_kind, s_channel, s_tx_frame_ctrl,
                    s_tx_seq, s_tx_irq, s_tx_fail_status, s_rx_irq, s_rx_frame_ctrl,
                    s_rx_seq, s_rx_rss}));
            end
        end
    end

    // Event driver: holds each transaction until taken, random gap before the next
    always @(negedge aclk) begin
        phy_event_t nxt;
        logic       nv;
        nv = s_valid;
        if (aresetn && !(s_valid && !ev_taken)) begin
            if (src_gap > 0) begin
                nv = 1'b0;
                src_gap--;
            end else if (ev_pending.size() != 0) begin
                nxt = ev_pending.pop_front();
                s_kind <= nxt.kind;
                s_channel <= nxt.channel;
                s_tx_frame_ctrl <= nxt.tx_frame_ctrl;
                s_tx_seq <= nxt.tx_seq;
                s_tx_irq <= nxt.tx_irq;
                s_tx_fail_status <= nxt.tx_fail_status;
                s_rx_irq <= nxt.rx_irq;
                s_rx_frame_ctrl <= nxt.rx_frame_ctrl;
                s_rx_seq <= nxt.rx_seq;
                s_rx_rss <= nxt.rx_rss;
                nv = 1'b1;
                if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
                src_gap = src_burst ? 0 : $urandom_range(0, 14);
            end else begin
                nv = 1'b0;
            end
        end
        s_valid <= nv;
    end

    // Result sink: random hold-off per result, plus one long stall
    always @(negedge aclk) begin
        logic nr;
        nr = m_ready;
        if (aresetn) begin
            if (long_hold != 0) begin
                nr = 1'b0;
            end else if (m_ready && !res_taken) begin
                nr = 1'b1;
            end else if (snk_gap > 0) begin
                nr = 1'b0;
                snk_gap--;
            end else begin
                nr = 1'b1;
                if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
                snk_gap = snk_burst ? 0 : $urandom_range(0, 14);
            end
        end
        m_ready <= nr;
    end

    // Long receiver stall once the random stream is under way
    always @(negedge aclk) begin
        if (long_hold != 0) begin
            long_hold <= long_hold - 1;
        end else if (!long_hold_done && events_sent >= HOLD_AT) begin
            long_hold <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d transactions sent, %0d results checked",
                     cycle_cnt, events_sent, results_checked);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        phy_event_t e;
        logic [4:0] ch;
        logic [7:0] seq;
        logic [7:0] ctl;

        phy_st = PHY_CODE_DISABLED;
        ack_wait_q = 1'b0;
        tx_busy_q = 1'b0;
        pend_ctrl = '0;
        pend_seq = '0;
        pend_ch = '0;
        listen_ch = '0;
        rss_q = '0;
        fail_q = 1'b0;

        // Directed: every event code from the key states, field extremes, ack cases
        e = rand_event(); e.kind = KIND_UNUSED;  ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_RECEIVE; ev_pending.push_back(e);   // busy when disabled
        e = rand_event(); e.kind = KIND_TX_REQ;  ev_pending.push_back(e);   // busy when disabled
        e = rand_event(); e.kind = KIND_SLEEP;   ev_pending.push_back(e);   // busy, still sleeps
        e = rand_event(); e.kind = KIND_DISABLE; ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_ENABLE;  ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_ENABLE;  ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_RECEIVE; e.channel = 5'd31; ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_ENABLE;  ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_DISABLE; ev_pending.push_back(e);
        // plain data frame at full signal strength
        e = rand_event(); e.kind = KIND_IRQ; e.tx_irq = 1'b0; e.rx_irq = 1'b1;
        e.rx_frame_ctrl = 8'h01; e.rx_rss = 8'hFF; ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_TICK;    ev_pending.push_back(e);   // nothing pending
        e = rand_event(); e.kind = KIND_TX_REQ; e.channel = 5'd31;
        e.tx_frame_ctrl = 8'hE0; e.tx_seq = 8'hFF; ev_pending.push_back(e);
        // re-request while idle in transmit overwrites the pending frame
        e = rand_event(); e.kind = KIND_TX_REQ; e.channel = 5'd31;
        e.tx_frame_ctrl = 8'hFF; e.tx_seq = 8'hAA; ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_TICK;    ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_TX_REQ;  ev_pending.push_back(e);   // busy while sending
        e = rand_event(); e.kind = KIND_IRQ; e.tx_irq = 1'b0; e.rx_irq = 1'b1;
        ev_pending.push_back(e);                                             // ignored while sending
        // transmit done with access failure, then an ack with the wrong sequence
        e = rand_event(); e.kind = KIND_IRQ; e.tx_irq = 1'b1; e.tx_fail_status = 1'b1;
        e.rx_irq = 1'b1; e.rx_frame_ctrl = 8'h02; e.rx_seq = 8'h55; e.rx_rss = 8'h00;
        ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_IRQ; e.tx_irq = 1'b0; e.rx_irq = 1'b1;
        e.rx_frame_ctrl = 8'h12; e.rx_seq = 8'hAA; ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_IRQ; e.tx_irq = 1'b1; e.rx_irq = 1'b0;
        ev_pending.push_back(e);                                             // stray tx complete
        e = rand_event(); e.kind = KIND_TX_REQ; e.channel = 5'd0;
        e.tx_frame_ctrl = 8'h00; e.tx_seq = 8'h00; ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_TICK;    ev_pending.push_back(e);   // short header, no ack
        e = rand_event(); e.kind = KIND_IRQ; e.tx_irq = 1'b1; e.tx_fail_status = 1'b0;
        e.rx_irq = 1'b1; e.rx_frame_ctrl = 8'h00; ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_TX_REQ;  ev_pending.push_back(e);
        e = rand_event(); e.kind = KIND_SLEEP;   ev_pending.push_back(e);   // busy from transmit
        n_queued = ev_pending.size();

        // Random: mostly complete transmit/ack exchanges, some frame traffic and noise
        while (n_queued < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    ch = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(11, 26));
                    seq = 8'($urandom_range(0, 255));
                    ctl = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 3) != 0) ctl[FC_ACK_REQ_BIT] = 1'b1;
                    if ($urandom_range(0, 2) != 0) begin
                        e = rand_event(); e.kind = KIND_ENABLE; ev_pending.push_back(e);
                    end
                    e = rand_event(); e.kind = KIND_RECEIVE; e.channel = ch;
                    ev_pending.push_back(e);
                    repeat ($urandom_range(0, 2)) begin
                        e = rand_event(); e.kind = KIND_IRQ; e.rx_irq = 1'b1;
                        ev_pending.push_back(e);
                    end
                    e = rand_event(); e.kind = KIND_TX_REQ; e.tx_frame_ctrl = ctl;
                    e.tx_seq = seq;
                    e.channel = ($urandom_range(0, 9) == 0) ? e.channel : ch;
                    ev_pending.push_back(e);
                    e = rand_event(); e.kind = KIND_TICK; ev_pending.push_back(e);
                    if ($urandom_range(0, 3) == 0) begin
                        e = rand_event(); e.kind = KIND_IRQ; e.tx_irq = 1'b0;
                        ev_pending.push_back(e);
                    end
                    e = rand_event(); e.kind = KIND_IRQ; e.tx_irq = 1'b1;
                    e.tx_fail_status = ($urandom_range(0, 3) == 0);
                    ev_pending.push_back(e);
                    if (ctl[FC_ACK_REQ_BIT]) begin
                        if ($urandom_range(0, 3) == 0) begin
                            e = rand_event(); e.kind = KIND_IRQ; e.rx_irq = 1'b1;
                            e.rx_frame_ctrl[2:0] = FC_TYPE_ACK; e.rx_seq = ~seq;
                            ev_pending.push_back(e);
                        end
                        e = rand_event(); e.kind = KIND_IRQ; e.rx_irq = 1'b1;
                        e.rx_frame_ctrl[2:0] = FC_TYPE_ACK;
                        e.rx_seq = ($urandom_range(0, 9) == 0) ? e.rx_seq : seq;
                        ev_pending.push_back(e);
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        e = rand_event(); e.kind = KIND_SLEEP; ev_pending.push_back(e);
                        if ($urandom_range(0, 1) == 0) begin
                            e = rand_event(); e.kind = KIND_DISABLE; ev_pending.push_back(e);
                        end
                    end
                end
                6, 7: begin
                    repeat ($urandom_range(1, 3)) begin
                        e = rand_event(); e.kind = KIND_IRQ; e.rx_irq = 1'b1;
                        ev_pending.push_back(e);
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 4)) ev_pending.push_back(rand_event());
                end
            endcase
            n_queued = events_sent + ev_pending.size() + (s_valid ? 1 : 0);
        end
        n_queued = ev_pending.size() + events_sent + (s_valid && !ev_taken ? 1 : 0);

        // Reset: held low from the start, released on a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        wait (events_sent == n_queued);
        wait (phy_results_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d events and %0d results over %0d cycles, incl. a %0d-cycle stall",
                 events_sent, results_checked, cycle_cnt, HOLD_CYCLES);
        $display("  busy %0d, tx starts %0d, tx done %0d, ack pending %0d, rx delivered %0d",
                 n_busy, n_starts, n_done, n_pending, n_deliver);
        if (fault_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
